// File: hdl/sem_pkg.sv
// package for the sobel edge magnitude block: widths, register indexes, helpers
// no dependencies
package sem_pkg;
	localparam int MaxWidth = 2048;
	localparam int AddrW = $clog2(MaxWidth);
	localparam int PixW = 24;
	localparam int CfgIdxW = 1;
	localparam int CfgDataW = 16;
	localparam logic [CfgIdxW-1:0] REG_WIDTH = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_HEIGHT = 1'd1;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic run_last;
		logic frame_end;
	} res_t;

	// signed gradient of one channel, range -1020..1020
	function automatic logic signed [11:0] grad(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c, input logic [7:0] d, input logic [7:0] e,
			input logic [7:0] f);
		logic signed [11:0] s;
		s = $signed({4'd0, d}) + $signed({3'd0, e, 1'b0}) + $signed({4'd0, f})
			- $signed({4'd0, a}) - $signed({3'd0, b, 1'b0}) - $signed({4'd0, c});
		return s;
	endfunction
endpackage

// File: hdl/sem_if.sv
// valid/ready stream channel carrying a payload of PW bits
// no dependencies
interface sem_if #(parameter int PW = 24) (input logic clk);
	logic valid;
	logic ready;
	logic [PW-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/sem_sqrt.sv
// rounded integer square root, saturated at 255, one result bit per cycle
// uses sem_pkg
module sem_sqrt import sem_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [20:0] n,
	output logic done,
	output logic [7:0] root
);
	logic [20:0] n_q;
	logic [7:0] r_q;
	logic [3:0] bit_q;
	logic busy_q;
	logic [8:0] trial;
	logic [17:0] sq;

	assign trial = {1'b0, r_q | (8'd1 << bit_q[2:0])};
	assign sq = trial * trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			bit_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q <= 4'd7;
			end else if (busy_q) begin
				if (bit_q == 4'd0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				bit_q <= bit_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= n;
			r_q <= '0;
		end else if (busy_q) begin
			if ({3'd0, sq} <= n_q) r_q <= trial[7:0];
		end
	end

	// round up when n exceeds r*r + r
	logic [17:0] rr;
	assign rr = {10'd0, r_q} * {10'd0, r_q} + {10'd0, r_q};
	assign root = (n_q >= 21'd65281) ? 8'd255 :
		((n_q > {3'd0, rr}) ? r_q + 8'd1 : r_q);
endmodule

// File: hdl/sobel_edge_magnitude_rgb.sv
// sobel edge magnitude on rgb pixels, top level
// uses sem_pkg, sem_if, sem_sqrt
// each item: accept, then S_READ for window and line stores, S_PICK to pick a result,
// then per result 3 channels (sum in S_CALC, root load, 8 root steps, take in S_ROOT)
// plus hand-out in S_OUT, which can stall on res.ready, and the next pick; up to 4 results
// arst_n clears counters, window and control; line stores are not cleared
module sobel_edge_magnitude_rgb import sem_pkg::*; (
	input logic clk,
	input logic arst_n,
	sem_if.sink pix,
	sem_if.source res,
	input logic cfg_we,
	input logic [CfgIdxW-1:0] cfg_idx,
	input logic [CfgDataW-1:0] cfg_data
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001, S_READ = 6'b000010, S_PICK = 6'b000100,
		S_CALC = 6'b001000, S_ROOT = 6'b010000, S_OUT = 6'b100000
	} st_t;

	st_t st_q;
	logic [11:0] width_q;
	logic [15:0] height_q;
	logic [15:0] row_q;
	logic [AddrW:0] col_q;
	// line stores, read data registered
	logic [PixW-1:0] upper_mem [MaxWidth];
	logic [PixW-1:0] lower_mem [MaxWidth];
	logic [PixW-1:0] up_rd_q, lo_rd_q;
	logic [PixW-1:0] win_q [3][3];
	logic [PixW-1:0] pix_q;
	logic [AddrW-1:0] addr_q;
	logic r1_q, r2_q, lc_q, lr_q, c0_q;
	logic [3:0] pend_q; // results still to give, one bit per kind
	logic [1:0] kind_q;
	logic [1:0] ch_q;
	logic [20:0] sum_q;
	logic [7:0] mag_q [3];
	res_t out_q;
	logic out_v_q;
	logic sq_start_q, sq_done;
	logic [7:0] sq_root;
	logic out_take;

	// effective geometry
	logic [11:0] w_eff;
	logic [15:0] h_eff;
	logic [AddrW:0] c_cl;
	logic last_col, last_row;
	always_comb begin
		w_eff = (width_q == 12'd0) ? 12'd1 : width_q;
		if (w_eff > 12'(MaxWidth)) w_eff = 12'(MaxWidth);
		h_eff = (height_q == 16'd0) ? 16'd1 : height_q;
		last_col = {1'b0, col_q} >= ({1'b0, w_eff} - 13'd1);
		last_row = row_q >= h_eff - 16'd1;
		c_cl = (col_q >= (AddrW+1)'(MaxWidth)) ? (AddrW+1)'(MaxWidth - 1) : col_q;
	end

	assign pix.ready = (st_q == S_IDLE);
	assign res.valid = out_v_q;
	assign res.data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 12'd640;
			height_q <= 16'd480;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_WIDTH: width_q <= cfg_data[11:0];
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// memory ports: read in S_IDLE on accept, write back in S_READ
	always_ff @(posedge clk) begin
		if (pix.valid && pix.ready) begin
			up_rd_q <= upper_mem[c_cl[AddrW-1:0]];
			lo_rd_q <= lower_mem[c_cl[AddrW-1:0]];
		end
		if (st_q == S_READ) begin
			upper_mem[addr_q] <= lo_rd_q;
			lower_mem[addr_q] <= pix_q;
		end
	end

	// window tap for the current result kind: row/col offset from kind bits
	logic [PixW-1:0] nb [3][3];
	logic [7:0] v [3][3];
	logic signed [11:0] gx, gy;
	always_comb begin
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				nb[i][j] = '0;
				if (i + int'(kind_q[1]) < 3 && j + int'(kind_q[0]) < 3)
					nb[i][j] = win_q[i + int'(kind_q[1])][j + int'(kind_q[0])];
				case (ch_q)
					2'd0: v[i][j] = nb[i][j][23:16];
					2'd1: v[i][j] = nb[i][j][15:8];
					default: v[i][j] = nb[i][j][7:0];
				endcase
			end
		gx = grad(v[0][0], v[1][0], v[2][0], v[0][2], v[1][2], v[2][2]);
		gy = grad(v[0][0], v[0][1], v[0][2], v[2][0], v[2][1], v[2][2]);
	end

	// squared sum is registered in S_CALC, root unit loads it the cycle after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_start_q <= 1'b0;
		else sq_start_q <= (st_q == S_CALC);
	end

	sem_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start_q), .n(sum_q),
		.done(sq_done), .root(sq_root)
	);

	// lowest pending kind, in raster order: 00, 01, 10, 11
	logic [1:0] next_kind;
	always_comb begin
		if (pend_q[0]) next_kind = 2'd0;
		else if (pend_q[1]) next_kind = 2'd1;
		else if (pend_q[2]) next_kind = 2'd2;
		else next_kind = 2'd3;
	end

	logic signed [22:0] gx2, gy2;
	assign gx2 = gx * gx;
	assign gy2 = gy * gy;

	assign out_take = (st_q == S_OUT) && (!out_v_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			row_q <= '0;
			col_q <= '0;
			pend_q <= '0;
			out_v_q <= 1'b0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) win_q[i][j] <= '0;
		end else begin
			if (res.valid && res.ready && !out_take) out_v_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (pix.valid) begin
						pix_q <= pix.data;
						addr_q <= c_cl[AddrW-1:0];
						r1_q <= row_q >= 16'd1;
						r2_q <= row_q >= 16'd2;
						lc_q <= last_col;
						lr_q <= last_row;
						c0_q <= col_q == '0;
						if (last_col) begin
							col_q <= '0;
							row_q <= last_row ? 16'd0 : row_q + 16'd1;
						end else begin
							col_q <= c_cl + 1'b1;
						end
						st_q <= S_READ;
					end
				end
				S_READ: begin
					for (int i = 0; i < 3; i++) begin
						win_q[i][0] <= c0_q ? '0 : win_q[i][1];
						win_q[i][1] <= win_q[i][2];
					end
					win_q[0][2] <= r2_q ? up_rd_q : '0;
					win_q[1][2] <= r1_q ? lo_rd_q : '0;
					win_q[2][2] <= pix_q;
					pend_q <= {lr_q & lc_q, lr_q & ~c0_q, r1_q & lc_q, r1_q & ~c0_q};
					st_q <= S_PICK;
				end
				S_PICK: begin
					if (pend_q == '0) st_q <= S_IDLE;
					else begin
						kind_q <= next_kind;
						ch_q <= 2'd0;
						st_q <= S_CALC;
					end
				end
				S_CALC: st_q <= S_ROOT;
				S_ROOT: begin
					if (sq_done) begin
						mag_q[ch_q] <= sq_root;
						if (ch_q == 2'd2) st_q <= S_OUT;
						else begin
							ch_q <= ch_q + 2'd1;
							st_q <= S_CALC;
						end
					end
				end
				S_OUT: begin
					if (out_take) begin
						out_q.red_out <= mag_q[0];
						out_q.green_out <= mag_q[1];
						out_q.blue_out <= mag_q[2];
						out_q.frame_end <= kind_q == 2'd3;
						out_q.run_last <= (pend_q & ~(4'd1 << kind_q)) == '0;
						out_v_q <= 1'b1;
						pend_q <= pend_q & ~(4'd1 << kind_q);
						st_q <= S_PICK;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		sum_q <= 21'(gx2) + 21'(gy2);
	end
endmodule

// File: hdl/sem_checker.sv
// port-level checks for the sobel edge magnitude block, bound to the top level
// uses sem_pkg
module sem_checker import sem_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_v,
	input logic in_r,
	input logic out_v,
	input logic out_r,
	input logic [25:0] out_d
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v && !out_r |=> out_v && $stable(out_d)) else $error("result dropped");
	a_fe_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_v && out_d[0] |-> out_d[1]) else $error("frame end not last");
	a_no_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_v && in_r |=> !in_r) else $error("item taken twice");
endmodule

bind sobel_edge_magnitude_rgb sem_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_v(pix.valid), .in_r(pix.ready),
	.out_v(res.valid), .out_r(res.ready), .out_d(res.data)
);

// File: dv/sobel_edge_magnitude_rgb_test.sv
// testbench for sobel_edge_magnitude_rgb: streams rgb frames, predicts every edge result
// depends on sem_pkg, sem_if and the block itself
module sobel_edge_magnitude_rgb_test;
	import sem_pkg::*;

	localparam int LimitCycles = 1500000;
	localparam int DrainCycles = 200;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_idx;
	logic [CfgDataW-1:0] cfg_data;

	sem_if #(.PW(PixW)) pix (clk);
	sem_if #(.PW($bits(res_t))) res (clk);

	sobel_edge_magnitude_rgb dut (
		.clk(clk), .arst_n(arst_n), .pix(pix.sink), .res(res.source),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// predictor state, mirrors the block
	int unsigned cur_width, cur_height;
	logic [23:0] upper_row [MaxWidth];
	logic [23:0] lower_row [MaxWidth];
	logic [23:0] win [3][3];
	int unsigned row_pos, col_pos;

	res_t edge_queue[$];
	int n_bad;
	bit failed;
	longint unsigned cycles;
	bit quiet_sink;

	// directed rows: width, height, pixel pattern code
	typedef enum int {PAT_ZERO, PAT_FULL, PAT_CHECKER, PAT_RAMP, PAT_RAND} pat_e;
	typedef struct {
		int unsigned w;
		int unsigned h;
		pat_e pat;
	} frame_row_t;

	frame_row_t directed[] = '{
		'{1, 1, PAT_FULL},
		'{1, 3, PAT_CHECKER},
		'{3, 1, PAT_FULL},
		'{3, 3, PAT_ZERO},
		'{3, 3, PAT_CHECKER},
		'{4, 3, PAT_RAMP}
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LimitCycles) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// rounded integer root, saturated at 255
	function automatic logic [7:0] root_round(int unsigned n);
		int unsigned r;
		if (n >= 65281) return 8'd255;
		r = 0;
		while ((r + 1) * (r + 1) <= n) r++;
		if (n > r * r + r) r++;
		return (r > 255) ? 8'd255 : r[7:0];
	endfunction

	function automatic logic [7:0] channel_edge(logic [23:0] nb[3][3], int sh);
		int v[3][3];
		int gx, gy;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				v[i][j] = (nb[i][j] >> sh) & 8'hff;
		gx = -v[0][0] + v[0][2] - 2 * v[1][0] + 2 * v[1][2] - v[2][0] + v[2][2];
		gy = -v[0][0] - 2 * v[0][1] - v[0][2] + v[2][0] + 2 * v[2][1] + v[2][2];
		return root_round(gx * gx + gy * gy);
	endfunction

	function automatic res_t edge_at(int ro, int co);
		logic [23:0] nb[3][3];
		res_t e;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				nb[i][j] = (i + ro < 3 && j + co < 3) ? win[i + ro][j + co] : 24'd0;
		e.red_out = channel_edge(nb, 16);
		e.green_out = channel_edge(nb, 8);
		e.blue_out = channel_edge(nb, 0);
		e.run_last = 1'b0;
		e.frame_end = 1'b0;
		return e;
	endfunction

	// advance the window by one pixel and queue what it releases
	task automatic predict_pixel(logic [23:0] p);
		int unsigned w, h, c, r;
		bit lc, lr;
		res_t got[$];
		w = (cur_width < 1) ? 1 : (cur_width > MaxWidth ? MaxWidth : cur_width);
		h = (cur_height < 1) ? 1 : cur_height;
		c = col_pos;
		r = row_pos;
		lc = c >= w - 1;
		lr = r >= h - 1;
		if (c >= MaxWidth) c = MaxWidth - 1;
		if (c == 0)
			for (int i = 0; i < 3; i++) begin
				win[i][0] = '0;
				win[i][1] = '0;
			end
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = (r >= 2) ? upper_row[c] : 24'd0;
		win[1][2] = (r >= 1) ? lower_row[c] : 24'd0;
		win[2][2] = p;
		upper_row[c] = lower_row[c];
		lower_row[c] = p;
		if (r >= 1 && c >= 1) got.push_back(edge_at(0, 0));
		if (r >= 1 && lc) got.push_back(edge_at(0, 1));
		if (lr && c >= 1) got.push_back(edge_at(1, 0));
		if (lr && lc) begin
			got.push_back(edge_at(1, 1));
			got[$].frame_end = 1'b1;
		end
		if (got.size() > 0) got[$].run_last = 1'b1;
		foreach (got[k]) edge_queue.push_back(got[k]);
		if (lc) begin
			col_pos = 0;
			row_pos = lr ? 0 : ((r + 1) & 16'hffff);
		end else begin
			col_pos = c + 1;
		end
	endtask

	function automatic logic [23:0] pattern_pixel(pat_e pt, int unsigned k);
		case (pt)
			PAT_ZERO: return 24'h000000;
			PAT_FULL: return 24'hffffff;
			PAT_CHECKER: return k[0] ? 24'hffffff : 24'h000000;
			PAT_RAMP: return {k[7:0] * 8'd37, 8'hff - k[7:0], k[7:0] ^ 8'ha5};
			default: return 24'($urandom_range(0, 24'hffffff));
		endcase
	endfunction

	function automatic bit take_gap(int n);
		return (n % 400 >= 250) ? 1'b0 : ($urandom_range(0, 99) < 37);
	endfunction

	// register writes only while idle
	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WIDTH) cur_width = val[11:0];
		else cur_height = val;
	endtask

	task automatic wait_idle();
		pix.valid <= 1'b0;
		while (edge_queue.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	int unsigned sent;

	task automatic send_pixel(logic [23:0] p);
		if (take_gap(sent)) begin
			pix.valid <= 1'b0;
			@(posedge clk);
			while (take_gap(sent)) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.data <= p;
		@(posedge clk);
		while (!pix.ready) @(posedge clk);
		predict_pixel(p);
		sent++;
	endtask

	task automatic send_frame(int unsigned w, int unsigned h, pat_e pt);
		int unsigned n;
		n = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
		write_reg(REG_WIDTH, CfgDataW'(w));
		write_reg(REG_HEIGHT, CfgDataW'(h));
		for (int unsigned k = 0; k < n; k++) send_pixel(pattern_pixel(pt, k));
		wait_idle();
	endtask

	// result side: random stall (none while quiet_sink), compare against oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			res.ready <= quiet_sink ? 1'b1 : ($urandom_range(0, 99) >= 37);
			if (res.valid && res.ready) begin
				res_t act, exp_r;
				act = res.data;
				if (edge_queue.size() == 0) begin
					failed = 1'b1;
					n_bad++;
					if (n_bad <= 10) $display("unexpected result %h", act);
				end else begin
					exp_r = edge_queue.pop_front();
					if (act !== exp_r) begin
						failed = 1'b1;
						n_bad++;
						if (n_bad <= 10)
							$display("mismatch: expected %h got %h", exp_r, act);
					end
				end
			end
		end
	end

	initial begin
		int unsigned w, h;
		cycles = 0;
		failed = 1'b0;
		n_bad = 0;
		sent = 0;
		quiet_sink = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_WIDTH;
		cfg_data = '0;
		pix.valid = 1'b0;
		pix.data = '0;
		res.ready = 1'b0;
		cur_width = 640;
		cur_height = 480;
		row_pos = 0;
		col_pos = 0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) win[i][j] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// a flat frame has no edges: zero magnitudes after reset
		write_reg(REG_WIDTH, 16'd2);
		write_reg(REG_HEIGHT, 16'd2);
		for (int k = 0; k < 4; k++) send_pixel(24'h000000);
		wait_idle();

		// zero width and zero height both count as one
		send_frame(0, 0, PAT_FULL);
		foreach (directed[d]) send_frame(directed[d].w, directed[d].h, directed[d].pat);
		// a wide row over two lines, and the largest height on a one-pixel column
		send_frame(64, 2, PAT_RAND);
		write_reg(REG_HEIGHT, 16'hffff);
		write_reg(REG_WIDTH, 16'd1);
		for (int k = 0; k < 6; k++) send_pixel(pattern_pixel(PAT_RAND, k));
		// go on in that frame cheaply: the user must not shrink height mid-frame once counters
		// are past, and the block does not enforce it; so just keep a full-scale stream in it
		quiet_sink = 1'b1;
		for (int k = 0; k < 40; k++) send_pixel(pattern_pixel(PAT_FULL, k));
		quiet_sink = 1'b0;
		wait_idle();
		// restart cleanly with a fresh reset-free frame start: finish it via height 1
		write_reg(REG_HEIGHT, 16'd1);
		send_pixel(24'h123456);
		wait_idle();

		// random frames, small sizes
		while (sent < 420) begin
			w = $urandom_range(1, 9);
			h = $urandom_range(1, 7);
			send_frame(w, h, ($urandom_range(0, 3) == 0) ? PAT_CHECKER : PAT_RAND);
		end

		wait_idle();
		if (!failed && edge_queue.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
